>>> rtl/r2k_pkg.sv
package r2k_pkg;

   localparam int NumRule3 = 3;
   localparam int NumRule2 = 60;
   localparam int NumRule1 = 5;

   localparam logic [1:0] CMD_FEED  = 2'd0;
   localparam logic [1:0] CMD_FLUSH = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   localparam logic [6:0] TOK_SMALL_TSU = 7'd68;
   localparam logic [6:0] TOK_SYLL_N    = 7'd69;
   localparam logic [6:0] TOK_ERROR     = 7'd70;

   localparam logic [7:0] CH_N    = 8'h6e;
   localparam logic [7:0] CH_Y    = 8'h79;
   localparam logic [7:0] CH_APOS = 8'h27;
   localparam logic [7:0] CH_LO_A = 8'h61;
   localparam logic [7:0] CH_LO_Z = 8'h7a;
   localparam logic [7:0] CH_UP_A = 8'h41;
   localparam logic [7:0] CH_UP_Z = 8'h5a;

   localparam logic [23:0] RULE3 [NumRule3] = '{"shi", "chi", "tsu"};

   localparam logic [15:0] RULE2 [NumRule2] = '{
      "ka", "ki", "ku", "ke", "ko", "sa", "su", "se", "so", "ta", "te", "to",
      "na", "ni", "nu", "ne", "no", "ha", "hi", "fu", "he", "ho",
      "ma", "mi", "mu", "me", "mo", "ya", "yu", "yo",
      "ra", "ri", "ru", "re", "ro", "wa", "wo",
      "ga", "gi", "gu", "ge", "go", "za", "ji", "zu", "ze", "zo",
      "da", "de", "do", "ba", "bi", "bu", "be", "bo",
      "pa", "pi", "pu", "pe", "po"
   };

   localparam logic [7:0] RULE1 [NumRule1] = '{"a", "i", "u", "e", "o"};

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] ch;
   } req_payload_type;

   typedef struct packed {
      logic [6:0] token;
      logic       last;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STEP,
      ST_BAD
   } state_type;

   typedef struct packed {
      logic load_feed;
      logic load_flush;
      logic clear;
      logic step;
      logic emit_err;
   } dp_cmd_type;

   typedef struct packed {
      logic ch_ok;
      logic out_free;
      logic step_emit;
      logic step_last;
   } dp_sts_type;

   typedef struct packed {
      logic       emit;
      logic [6:0] token;
      logic [1:0] drop;
   } step_type;

   function automatic logic vowel_ch(input logic [7:0] c);
      return (c == "a") || (c == "i") || (c == "u") || (c == "e") || (c == "o");
   endfunction

   function automatic logic is_cons(input logic [7:0] c);
      return (c >= CH_LO_A) && (c <= CH_LO_Z) && !vowel_ch(c);
   endfunction

   function automatic step_type red_step(input logic [7:0] c0, input logic [7:0] c1,
                                         input logic [7:0] c2, input logic [1:0] n,
                                         input logic fin);
      step_type s;
      logic     found;
      logic     waits;
      s     = '{emit: 1'b0, token: TOK_ERROR, drop: 2'd1};
      found = 1'b0;
      waits = 1'b0;
      if (n == 2'd0) begin
         s.emit = 1'b0;
      end else if (n >= 2'd2 && is_cons(c0) && c0 == c1 && c0 != CH_N) begin
         s = '{emit: 1'b1, token: TOK_SMALL_TSU, drop: 2'd1};
      end else if (n >= 2'd2 && c0 == CH_N && (c1 == CH_APOS || c1 == CH_N)) begin
         s = '{emit: 1'b1, token: TOK_SYLL_N, drop: 2'd2};
      end else if (n >= 2'd2 && c0 == CH_N && is_cons(c1) && c1 != CH_Y) begin
         s = '{emit: 1'b1, token: TOK_SYLL_N, drop: 2'd1};
      end else begin
         for (int i = 0; i < NumRule3; i++) begin
            if (!found && n == 2'd3 && {c0, c1, c2} == RULE3[i]) begin
               s     = '{emit: 1'b1, token: 7'(i), drop: 2'd3};
               found = 1'b1;
            end
         end
         for (int j = 0; j < NumRule2; j++) begin
            if (!found && n >= 2'd2 && {c0, c1} == RULE2[j]) begin
               s     = '{emit: 1'b1, token: 7'(NumRule3 + j), drop: 2'd2};
               found = 1'b1;
            end
         end
         for (int v = 0; v < NumRule1; v++) begin
            if (!found && c0 == RULE1[v]) begin
               s     = '{emit: 1'b1, token: 7'(NumRule3 + NumRule2 + v), drop: 2'd1};
               found = 1'b1;
            end
         end
         if (!found) begin
            if (fin && n == 2'd1 && c0 == CH_N) begin
               s = '{emit: 1'b1, token: TOK_SYLL_N, drop: 2'd1};
            end else begin
               for (int i = 0; i < NumRule3; i++) begin
                  if (n == 2'd1 && c0 == RULE3[i][23:16]) waits = 1'b1;
                  if (n == 2'd2 && {c0, c1} == RULE3[i][23:8]) waits = 1'b1;
               end
               for (int j = 0; j < NumRule2; j++) begin
                  if (n == 2'd1 && c0 == RULE2[j][15:8]) waits = 1'b1;
               end
               s = '{emit: !waits, token: TOK_ERROR, drop: 2'd1};
            end
         end
      end
      return s;
   endfunction

endpackage

>>> rtl/r2k_ctrl.sv
module r2k_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_cmd,
   input  r2k_pkg::dp_sts_type      dp_sts,
   output r2k_pkg::dp_cmd_type      dp_cmd
);
   import r2k_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      dp_cmd    = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_cmd)
                  CMD_FEED: begin
                     if (dp_sts.ch_ok) begin
                        dp_cmd.load_feed = 1'b1;
                        state_in         = ST_STEP;
                     end else begin
                        dp_cmd.clear = 1'b1;
                        state_in     = ST_BAD;
                     end
                  end
                  CMD_FLUSH: begin
                     dp_cmd.load_flush = 1'b1;
                     state_in          = ST_STEP;
                  end
                  CMD_CLEAR: begin
                     dp_cmd.clear = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_STEP: begin
            if (!dp_sts.step_emit) begin
               state_in = ST_IDLE;
            end else if (dp_sts.out_free) begin
               dp_cmd.step = 1'b1;
               if (dp_sts.step_last) state_in = ST_IDLE;
            end
         end
         ST_BAD: begin
            if (dp_sts.out_free) begin
               dp_cmd.emit_err = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef ASSERT_OFF
   a_step_needs_room: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.step || dp_cmd.emit_err) |-> dp_sts.out_free)
      else $error("token issued while output register held");
   a_bad_then_err: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BAD && dp_sts.out_free) |=> (state_ff == ST_IDLE))
      else $error("rejected character did not complete");
   a_wait_ends_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP && !dp_sts.step_emit) |=> (state_ff == ST_IDLE))
      else $error("step unit stayed busy with nothing to emit");
`endif

endmodule

>>> rtl/r2k_datapath.sv
module r2k_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  r2k_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output r2k_pkg::rsp_payload_type rsp_payload,
   input  r2k_pkg::dp_cmd_type      dp_cmd,
   output r2k_pkg::dp_sts_type      dp_sts
);
   import r2k_pkg::*;

   logic [7:0]      buf_ff [3];
   logic [7:0]      buf_in [3];
   logic [1:0]      cnt_ff;
   logic [1:0]      cnt_in;
   logic            final_ff;
   logic            final_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_payload_type rsp_ff;
   rsp_payload_type rsp_in;

   logic [7:0]      lc;
   logic [7:0]      nb [3];
   logic [1:0]      n_nxt;
   step_type        cur;
   step_type        nxt;

   always_comb begin
      lc = req_payload.ch;
      if (req_payload.ch >= CH_UP_A && req_payload.ch <= CH_UP_Z) lc = req_payload.ch | 8'h20;
   end

   assign cur = red_step(buf_ff[0], buf_ff[1], buf_ff[2], cnt_ff, final_ff);

   always_comb begin
      nb[0] = buf_ff[0];
      nb[1] = buf_ff[1];
      nb[2] = buf_ff[2];
      case (cur.drop)
         2'd1: begin
            nb[0] = buf_ff[1];
            nb[1] = buf_ff[2];
         end
         2'd2: begin
            nb[0] = buf_ff[2];
         end
         default: begin
         end
      endcase
      n_nxt = cnt_ff - cur.drop;
   end

   assign nxt = red_step(nb[0], nb[1], nb[2], n_nxt, final_ff);

   assign dp_sts.ch_ok     = (lc >= CH_LO_A && lc <= CH_LO_Z) || (lc == CH_APOS);
   assign dp_sts.out_free  = !rsp_valid_ff || rsp_ready;
   assign dp_sts.step_emit = cur.emit;
   assign dp_sts.step_last = !nxt.emit;

   always_comb begin
      buf_in       = buf_ff;
      cnt_in       = cnt_ff;
      final_in     = final_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (dp_cmd.clear) begin
         cnt_in = 2'd0;
      end
      if (dp_cmd.load_feed) begin
         case (cnt_ff)
            2'd0:    buf_in[0] = lc;
            2'd1:    buf_in[1] = lc;
            default: buf_in[2] = lc;
         endcase
         cnt_in   = cnt_ff + 2'd1;
         final_in = 1'b0;
      end
      if (dp_cmd.load_flush) begin
         final_in = 1'b1;
      end
      if (dp_cmd.step) begin
         buf_in       = nb;
         cnt_in       = n_nxt;
         rsp_in       = '{token: cur.token, last: !nxt.emit};
         rsp_valid_in = 1'b1;
      end
      if (dp_cmd.emit_err) begin
         rsp_in       = '{token: TOK_ERROR, last: 1'b1};
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= 2'd0;
         final_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         final_ff     <= final_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef ASSERT_OFF
   a_drop_in_range: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.step |-> (cur.drop <= cnt_ff))
      else $error("step drops more characters than buffered");
   a_last_leaves_short: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.step && !nxt.emit) |=> (cnt_ff <= 2'd2))
      else $error("pending buffer left with three characters");
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("waiting token changed or dropped");
`endif

endmodule

>>> rtl/romaji_to_kana_tokenizer.sv
// channel | direction | handshake          | payload
// req     | in        | req_valid/req_ready | cmd, ch
// rsp     | out       | rsp_valid/rsp_ready | token, last
//
// a feed or flush transaction is taken by the control FSM, then one token leaves per cycle
// from the reduction step unit while the output register is free to take it
// clear and unused commands leave the FSM idle; a rejected character clears the pending buffer and emits an error token
// reset (synchronous) empties the pending buffer at once
// a stalled rsp channel holds the step unit; the next request can be taken while the
// final token of the previous one waits in the output register
module romaji_to_kana_tokenizer (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  r2k_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output r2k_pkg::rsp_payload_type rsp_payload
);
   import r2k_pkg::*;

   dp_cmd_type dp_cmd;
   dp_sts_type dp_sts;

   r2k_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_payload.cmd),
      .dp_sts    (dp_sts),
      .dp_cmd    (dp_cmd)
   );

   r2k_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .dp_cmd      (dp_cmd),
      .dp_sts      (dp_sts)
   );

endmodule

>>> verif/romaji_to_kana_tokenizer_tb.sv
`timescale 1ns / 1ps

module romaji_to_kana_tokenizer_tb;
   import r2k_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [6:0] TK_KA      = 7'd3;
   localparam logic [6:0] TK_A       = 7'd63;
   localparam logic [6:0] TK_O       = 7'd67;
   localparam int         RAND_ITEMS = 120;
   localparam int         CHOKE_AT   = 40;
   localparam int         CHOKE_LEN  = 120;

   typedef struct packed {
      req_payload_type       item;
      logic                  typed;
      logic [1:0]            n_tok;
      logic [0:2][6:0]       tok;
   } key_row_type;

   localparam key_row_type KEY_SCRIPT [27] = '{
      '{'{CMD_FLUSH, 8'h00}, 1'b1, 2'd0, '{7'd0, 7'd0, 7'd0}},
      '{'{CMD_CLEAR, 8'hff}, 1'b1, 2'd0, '{7'd0, 7'd0, 7'd0}},
      '{'{CMD_UNUSED, 8'h55}, 1'b1, 2'd0, '{7'd0, 7'd0, 7'd0}},
      '{'{CMD_FEED, "a"}, 1'b1, 2'd1, '{TK_A, 7'd0, 7'd0}},
      '{'{CMD_FEED, "O"}, 1'b1, 2'd1, '{TK_O, 7'd0, 7'd0}},
      '{'{CMD_FEED, 8'h00}, 1'b1, 2'd1, '{TOK_ERROR, 7'd0, 7'd0}},
      '{'{CMD_FEED, 8'hff}, 1'b1, 2'd1, '{TOK_ERROR, 7'd0, 7'd0}},
      '{'{CMD_FEED, CH_APOS}, 1'b1, 2'd1, '{TOK_ERROR, 7'd0, 7'd0}},
      '{'{CMD_FEED, "k"}, 1'b1, 2'd0, '{7'd0, 7'd0, 7'd0}},
      '{'{CMD_FEED, "K"}, 1'b1, 2'd1, '{TOK_SMALL_TSU, 7'd0, 7'd0}},
      '{'{CMD_FEED, "a"}, 1'b1, 2'd1, '{TK_KA, 7'd0, 7'd0}},
      '{'{CMD_FEED, "n"}, 1'b1, 2'd0, '{7'd0, 7'd0, 7'd0}},
      '{'{CMD_FLUSH, 8'h00}, 1'b1, 2'd1, '{TOK_SYLL_N, 7'd0, 7'd0}},
      '{'{CMD_FEED, "s"}, 1'b1, 2'd0, '{7'd0, 7'd0, 7'd0}},
      '{'{CMD_FEED, "h"}, 1'b1, 2'd0, '{7'd0, 7'd0, 7'd0}},
      '{'{CMD_FLUSH, 8'hff}, 1'b1, 2'd0, '{7'd0, 7'd0, 7'd0}},
      '{'{CMD_FEED, "x"}, 1'b1, 2'd3, '{TOK_ERROR, TOK_ERROR, TOK_ERROR}},
      '{'{CMD_FEED, "n"}, 1'b0, 2'd0, '{7'd0, 7'd0, 7'd0}},
      '{'{CMD_FEED, CH_APOS}, 1'b0, 2'd0, '{7'd0, 7'd0, 7'd0}},
      '{'{CMD_FEED, "n"}, 1'b0, 2'd0, '{7'd0, 7'd0, 7'd0}},
      '{'{CMD_FEED, "b"}, 1'b0, 2'd0, '{7'd0, 7'd0, 7'd0}},
      '{'{CMD_FEED, "Z"}, 1'b0, 2'd0, '{7'd0, 7'd0, 7'd0}},
      '{'{CMD_FEED, "a"}, 1'b0, 2'd0, '{7'd0, 7'd0, 7'd0}},
      '{'{CMD_FEED, "s"}, 1'b0, 2'd0, '{7'd0, 7'd0, 7'd0}},
      '{'{CMD_CLEAR, 8'h00}, 1'b1, 2'd0, '{7'd0, 7'd0, 7'd0}},
      '{'{CMD_FEED, "n"}, 1'b0, 2'd0, '{7'd0, 7'd0, 7'd0}},
      '{'{CMD_FEED, "y"}, 1'b0, 2'd0, '{7'd0, 7'd0, 7'd0}}
   };

   string kana_rules [68] = '{
      "shi", "chi", "tsu",
      "ka", "ki", "ku", "ke", "ko", "sa", "su", "se", "so", "ta", "te", "to",
      "na", "ni", "nu", "ne", "no", "ha", "hi", "fu", "he", "ho",
      "ma", "mi", "mu", "me", "mo", "ya", "yu", "yo",
      "ra", "ri", "ru", "re", "ro", "wa", "wo",
      "ga", "gi", "gu", "ge", "go", "za", "ji", "zu", "ze", "zo",
      "da", "de", "do", "ba", "bi", "bu", "be", "bo",
      "pa", "pi", "pu", "pe", "po",
      "a", "i", "u", "e", "o"
   };

   string after_n = "'nybcdfghjkmprstwz";

   logic            clock = 1'b0;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_payload;

   logic [7:0]      pend [3];
   int              pend_n = 0;
   rsp_payload_type kana_due [$];
   req_payload_type keystrokes [$];
   int              rsp_count = 0;
   bit              failed = 1'b0;

   romaji_to_kana_tokenizer u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int pick_gap();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
   endfunction

   function automatic bit cons_ch(input logic [7:0] c);
      return c >= CH_LO_A && c <= CH_LO_Z && c != "a" && c != "i" && c != "u"
             && c != "e" && c != "o";
   endfunction

   function automatic void drop_pending(input int cnt);
      if (cnt >= pend_n) begin
         pend_n = 0;
      end else begin
         for (int i = 0; i + cnt < pend_n; i++) pend[i] = pend[i + cnt];
         pend_n = pend_n - cnt;
      end
   endfunction

   // advances the pending buffer and, when keep is set, queues the tokens the item should produce
   function automatic void predict_kana(input req_payload_type p, input bit keep);
      logic [6:0]      toks [$];
      logic [7:0]      c;
      bit              run;
      bit              fin;
      bit              hit;
      bit              waits;
      bit              same;
      int              l;
      rsp_payload_type e;
      c   = p.ch;
      fin = (p.cmd == CMD_FLUSH);
      run = 1'b0;
      if (p.cmd == CMD_CLEAR) begin
         pend_n = 0;
      end else if (p.cmd == CMD_FLUSH) begin
         run = 1'b1;
      end else if (p.cmd == CMD_FEED) begin
         if (c >= CH_UP_A && c <= CH_UP_Z) c = c + 8'h20;
         if (!(c >= CH_LO_A && c <= CH_LO_Z) && c != CH_APOS) begin
            pend_n = 0;
            toks.push_back(TOK_ERROR);
         end else begin
            pend[pend_n] = c;
            pend_n++;
            run = 1'b1;
         end
      end
      while (run && pend_n > 0 && toks.size() < 3) begin
         if (pend_n >= 2 && cons_ch(pend[0]) && pend[0] == pend[1] && pend[0] != CH_N) begin
            toks.push_back(TOK_SMALL_TSU);
            drop_pending(1);
         end else if (pend_n >= 2 && pend[0] == CH_N && (pend[1] == CH_APOS || pend[1] == CH_N)) begin
            toks.push_back(TOK_SYLL_N);
            drop_pending(2);
         end else if (pend_n >= 2 && pend[0] == CH_N && cons_ch(pend[1])
                      && pend[1] != CH_Y) begin
            toks.push_back(TOK_SYLL_N);
            drop_pending(1);
         end else begin
            hit = 1'b0;
            for (int r = 0; r < 68; r++) begin
               l = kana_rules[r].len();
               if (!hit && pend_n >= l) begin
                  same = 1'b1;
                  for (int j = 0; j < l; j++) if (pend[j] != kana_rules[r][j]) same = 1'b0;
                  if (same) begin
                     hit = 1'b1;
                     toks.push_back(7'(r));
                     drop_pending(l);
                  end
               end
            end
            if (!hit) begin
               if (fin && pend_n == 1 && pend[0] == CH_N) begin
                  toks.push_back(TOK_SYLL_N);
                  drop_pending(1);
               end else begin
                  waits = 1'b0;
                  for (int r = 0; r < 68; r++) begin
                     if (pend_n <= kana_rules[r].len()) begin
                        same = 1'b1;
                        for (int j = 0; j < pend_n; j++)
                           if (pend[j] != kana_rules[r][j]) same = 1'b0;
                        if (same) waits = 1'b1;
                     end
                  end
                  if (waits) begin
                     run = 1'b0;
                  end else begin
                     toks.push_back(TOK_ERROR);
                     drop_pending(1);
                  end
               end
            end
         end
      end
      if (pend_n > 2) pend_n = 2;
      if (keep) begin
         foreach (toks[i]) begin
            e.token = toks[i];
            e.last  = (i == toks.size() - 1);
            kana_due.push_back(e);
         end
      end
   endfunction

   function automatic void queue_char(input logic [7:0] c);
      logic [7:0] k;
      k = c;
      if (k >= CH_LO_A && k <= CH_LO_Z && $urandom_range(0, 3) == 0) k = k - 8'h20;
      keystrokes.push_back('{cmd: CMD_FEED, ch: k});
   endfunction

   function automatic void queue_word(input string w);
      for (int j = 0; j < w.len(); j++) queue_char(w[j]);
   endfunction

   task automatic send_item(input req_payload_type p, input bit keep);
      int gap;
      gap = $urandom_range(0, 1) ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (!req_ready);
      predict_kana(p, keep);
   endtask

   initial begin : rsp_sink
      bit choked;
      choked    = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!choked && rsp_count >= CHOKE_AT) begin
            choked = 1'b1;
            rsp_ready <= 1'b0;
            repeat (CHOKE_LEN) @(posedge clock);
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat (pick_gap()) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_payload_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count++;
         if (kana_due.size() == 0) begin
            $display("%0t: token %0d last %0b with none expected", $time,
                     rsp_payload.token, rsp_payload.last);
            failed = 1'b1;
         end else begin
            e = kana_due.pop_front();
            if (rsp_payload.token !== e.token) begin
               $display("%0t: token expected %0d actual %0d", $time, e.token,
                        rsp_payload.token);
               failed = 1'b1;
            end
            if (rsp_payload.last !== e.last) begin
               $display("%0t: last expected %0b actual %0b", $time, e.last,
                        rsp_payload.last);
               failed = 1'b1;
            end
         end
      end
   end

   initial begin : stimulus
      req_payload_type p;
      rsp_payload_type e;
      int              sent;
      int              kind;
      int              r;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      sent        = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (KEY_SCRIPT[i]) begin
         send_item(KEY_SCRIPT[i].item, !KEY_SCRIPT[i].typed);
         if (KEY_SCRIPT[i].typed) begin
            for (int t = 0; t < KEY_SCRIPT[i].n_tok; t++) begin
               e.token = KEY_SCRIPT[i].tok[t];
               e.last  = (t == KEY_SCRIPT[i].n_tok - 1);
               kana_due.push_back(e);
            end
         end
      end

      while (sent < RAND_ITEMS) begin
         kind = $urandom_range(0, 99);
         if (kind < 55) begin
            queue_word(kana_rules[$urandom_range(0, 67)]);
         end else if (kind < 65) begin
            queue_char(CH_N);
            queue_char(after_n[$urandom_range(0, after_n.len() - 1)]);
            queue_word(kana_rules[$urandom_range(0, 67)]);
         end else if (kind < 73) begin
            r = $urandom_range(0, 62);
            queue_char(kana_rules[r][0]);
            queue_word(kana_rules[r]);
         end else if (kind < 81) begin
            if ($urandom_range(0, 1)) queue_char(CH_LO_A + 8'($urandom_range(0, 25)));
            keystrokes.push_back('{cmd: CMD_FLUSH, ch: 8'($urandom)});
         end else if (kind < 86) begin
            keystrokes.push_back('{cmd: CMD_CLEAR, ch: 8'($urandom)});
         end else if (kind < 89) begin
            keystrokes.push_back('{cmd: CMD_UNUSED, ch: 8'($urandom)});
         end else if (kind < 95) begin
            queue_char(CH_LO_A + 8'($urandom_range(0, 25)));
         end else begin
            keystrokes.push_back('{cmd: CMD_FEED, ch: 8'($urandom)});
         end
         while (keystrokes.size() != 0) begin
            p = keystrokes.pop_front();
            send_item(p, 1'b1);
            if (p.cmd != CMD_UNUSED) sent++;
         end
      end
      req_valid <= 1'b0;

      while (kana_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (!failed) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #5000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
